// File: rtl/elevator_status_frame_deframer_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the elevator status frame deframer
// Shared assertion shorthands, clocked on clk and held off during rst.
// ----------------------------------------------------------------------------
`ifndef ELEVATOR_STATUS_FRAME_DEFRAMER_MACROS_SVH
`define ELEVATOR_STATUS_FRAME_DEFRAMER_MACROS_SVH

// same-cycle implication
`define ESFD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ESFD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/esfd_pkg.sv
// ----------------------------------------------------------------------------
// esfd_pkg
// Types and constants shared by the elevator status frame deframer.
// ----------------------------------------------------------------------------
package esfd_pkg;

  localparam int NUM_LINKS     = 4;
  localparam int NUM_ELEVATORS = 16;
  localparam int FRAME_LEN     = 8;

  localparam int LINK_IW  = (NUM_LINKS > 1) ? $clog2(NUM_LINKS) : 1;
  localparam int ELEV_IW  = (NUM_ELEVATORS > 1) ? $clog2(NUM_ELEVATORS) : 1;
  localparam int PHASE_W  = $clog2(FRAME_LEN);

  localparam logic [8:0] ELEV_COUNT = 9'(NUM_ELEVATORS);

  localparam logic [7:0] HDR_FIRST   = 8'hAA;
  localparam logic [7:0] HDR_SECOND  = 8'h55;
  localparam logic [7:0] FLAG_VALID  = 8'h01;
  localparam logic [7:0] FLOOR_RESET = 8'hFF;

  // configuration register indexes
  localparam int REG_IDX_W = 2;
  localparam logic [REG_IDX_W-1:0] REG_ARRIVAL    = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_STATUS_ACK = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_INIT_ACK   = 2'd2;

  // per-link receive phase: hunt, second header byte, then frame bytes 2..7
  typedef enum logic [PHASE_W-1:0] {
    PH_HUNT  = 3'd0,
    PH_HDR2  = 3'd1,
    PH_FLOOR = 3'd2,
    PH_FLAG  = 3'd3,
    PH_CMD   = 3'd4,
    PH_ID    = 3'd5,
    PH_ROBOT = 3'd6,
    PH_CSUM  = 3'd7
  } phase_t;

  typedef enum logic [1:0] {
    KIND_FLOOR = 2'd0,
    KIND_RESET = 2'd1,
    KIND_NONE  = 2'd2
  } kind_t;

  typedef struct packed {
    logic [7:0] arrival;
    logic [7:0] status_ack;
    logic [7:0] init_ack;
  } cfg_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] id;
    logic [7:0] floor;
  } frame_t;

  typedef struct packed {
    kind_t             kind;
    logic [7:0]        id;
    logic signed [7:0] door_floor;
    logic              reset_done;
    logic              applied;
  } result_t;

endpackage

// File: rtl/elevator_status_frame_deframer.sv
// ----------------------------------------------------------------------------
// elevator_status_frame_deframer
// Per-link deframing of elevator status frames with an elevator state table.
// ----------------------------------------------------------------------------
// Usage:
//  - Slave stream: one received byte per request, s_tdata = byte, s_tuser =
//    link number. Each link hunts for the 0xAA 0x55 header on its own and
//    collects six more bytes; the eighth byte of a frame completes it.
//  - Master stream: one request per completed frame, m_tuser = frame kind
//    (floor update, reset acknowledge, no effect), m_tdata = elevator id,
//    stored open-door floor, stored reset-ok flag and an in-table flag.
//    Header and data bytes, and bytes on links outside the range, give none.
//  - Config: cfg_wen/cfg_idx/cfg_data write the arrival, status-ack and
//    init-ack command codes; write them only while the block is idle.
//  - Throughput: one byte per cycle, sustained while no stall drops s_tready, any mix of links.
//  - Path: the result of a frame shows on m_tvalid once the request carrying
//    its last byte has passed the input register, frame register, table
//    read register and result register.
//  - Stall: the frame, table-read and result registers hold one frame each,
//    so bytes keep flowing while a result waits; s_tready drops only when a
//    completing byte finds all of them full.
//  - Reset: synchronous rst puts every link back to hunting, floors to -1,
//    reset-ok flags to 0 and the codes to 0/1/2. No clearing pass.
// ----------------------------------------------------------------------------
module elevator_status_frame_deframer (
  input  logic                          clk,
  input  logic                          rst,
  // config write port
  input  logic                          cfg_wen,
  input  logic [esfd_pkg::REG_IDX_W-1:0] cfg_idx,
  input  logic [7:0]                    cfg_data,
  // received bytes
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [7:0]                    s_tdata,   // [7:0] rx_byte
  input  logic [1:0]                    s_tuser,   // [1:0] link_id
  // frame results
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [23:0]                   m_tdata,   // [7:0] elevator_number,
                                                   // [15:8] door_floor,
                                                   // [16] reset_done,
                                                   // [17] entry_applied
  output logic [1:0]                    m_tuser    // [1:0] frame_kind
);
  import esfd_pkg::*;

  cfg_t    cfg;
  logic    fr_valid;
  logic    fr_ready;
  frame_t  fr;
  result_t res;

  // command code registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.arrival    <= 8'd0;
      cfg.status_ack <= 8'd1;
      cfg.init_ack   <= 8'd2;
    end else if (cfg_wen) begin
      case (cfg_idx)
        REG_ARRIVAL:    cfg.arrival    <= cfg_data;
        REG_STATUS_ACK: cfg.status_ack <= cfg_data;
        REG_INIT_ACK:   cfg.init_ack   <= cfg_data;
        default: begin
          // unmapped index: write dropped
        end
      endcase
    end
  end

  esfd_link_framer u_framer (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_req   (s_tvalid),
    .in_ready (s_tready),
    .link_id  (s_tuser),
    .rx_byte  (s_tdata),
    .fr_valid (fr_valid),
    .fr_ready (fr_ready),
    .fr       (fr)
  );

  esfd_elev_table u_table (
    .clk       (clk),
    .rst       (rst),
    .fr_valid  (fr_valid),
    .fr_ready  (fr_ready),
    .fr        (fr),
    .res_valid (m_tvalid),
    .res_ready (m_tready),
    .res       (res)
  );

  assign m_tdata = {6'd0, res.applied, res.reset_done, res.door_floor, res.id};
  assign m_tuser = res.kind;

endmodule

// File: rtl/esfd_link_framer.sv
// ----------------------------------------------------------------------------
// esfd_link_framer
// Input register, per-link header hunt and byte capture, frame register.
// ----------------------------------------------------------------------------
module esfd_link_framer (
  input  logic            clk,
  input  logic            rst,
  input  esfd_pkg::cfg_t  cfg,
  input  logic            in_req,
  output logic            in_ready,
  input  logic [1:0]      link_id,
  input  logic [7:0]      rx_byte,
  output logic            fr_valid,
  input  logic            fr_ready,
  output esfd_pkg::frame_t fr
);
  import esfd_pkg::*;

  logic              in_valid;
  logic [1:0]        in_link;
  logic [7:0]        in_byte;

  phase_t            phase [NUM_LINKS];
  logic [31:0]       capture [NUM_LINKS];

  logic [LINK_IW-1:0] lidx;
  logic              link_ok;
  phase_t            cur;
  phase_t            phase_next;
  logic              cap_we;
  logic [1:0]        cap_sel;
  logic              done;
  logic              fr_free;
  logic              stall;
  logic [31:0]       cap;
  frame_t            frame_next;

  assign lidx    = LINK_IW'(in_link);
  assign link_ok = ({30'd0, in_link} < 32'(NUM_LINKS));
  assign cur     = phase[lidx];

  // next phase
  always_comb begin
    case (cur)
      PH_HUNT: begin
        phase_next = (in_byte == HDR_FIRST) ? PH_HDR2 : PH_HUNT;
      end
      PH_HDR2: begin
        if (in_byte == HDR_SECOND) begin
          phase_next = PH_FLOOR;
        end else if (in_byte == HDR_FIRST) begin
          phase_next = PH_HDR2;
        end else begin
          phase_next = PH_HUNT;
        end
      end
      PH_CSUM: begin
        phase_next = PH_HUNT;
      end
      default: begin
        phase_next = phase_t'(cur + 3'd1);
      end
    endcase
  end

  // per-phase actions
  always_comb begin
    cap_we  = 1'b0;
    done    = 1'b0;
    cap_sel = 2'(cur - PH_FLOOR);
    case (cur)
      PH_FLOOR, PH_FLAG, PH_CMD, PH_ID: begin
        cap_we = 1'b1;
      end
      PH_CSUM: begin
        done = 1'b1;
      end
      default: begin
        cap_we = 1'b0;
      end
    endcase
  end

  // frame decode: arrival, then status ack (both need the flag), then init ack
  assign cap = capture[lidx];
  always_comb begin
    frame_next.floor = cap[7:0];
    frame_next.id    = cap[31:24];
    if (cap[23:16] == cfg.arrival && cap[15:8] == FLAG_VALID) begin
      frame_next.kind = KIND_FLOOR;
    end else if (cap[23:16] == cfg.status_ack && cap[15:8] == FLAG_VALID) begin
      frame_next.kind = KIND_FLOOR;
    end else if (cap[23:16] == cfg.init_ack) begin
      frame_next.kind = KIND_RESET;
    end else begin
      frame_next.kind = KIND_NONE;
    end
  end

  assign fr_free  = !fr_valid || fr_ready;
  assign stall    = in_valid && link_ok && done && !fr_free;
  assign in_ready = !in_valid || !stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      fr_valid <= 1'b0;
      for (int i = 0; i < NUM_LINKS; i++) begin
        phase[i] <= PH_HUNT;
      end
    end else begin
      if (in_ready) begin
        in_valid <= in_req;
      end
      if (in_valid && link_ok && !stall) begin
        phase[lidx] <= phase_next;
      end
      if (fr_free) begin
        fr_valid <= in_valid && link_ok && done;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      in_link <= link_id;
      in_byte <= rx_byte;
    end
    if (in_valid && link_ok && cap_we) begin
      capture[lidx][cap_sel*8 +: 8] <= in_byte;
    end
    if (fr_free) begin
      fr <= frame_next;
    end
  end

endmodule

// File: rtl/esfd_elev_table.sv
// ----------------------------------------------------------------------------
// esfd_elev_table
// Elevator floor / reset-ok table: read stage, update and result register.
// ----------------------------------------------------------------------------
module esfd_elev_table (
  input  logic              clk,
  input  logic              rst,
  input  logic              fr_valid,
  output logic              fr_ready,
  input  esfd_pkg::frame_t  fr,
  output logic              res_valid,
  input  logic              res_ready,
  output esfd_pkg::result_t res
);
  import esfd_pkg::*;

  logic [7:0]               floor_mem [NUM_ELEVATORS];
  logic [NUM_ELEVATORS-1:0] floor_set;
  logic [NUM_ELEVATORS-1:0] reset_ok;

  logic               rd_valid;
  frame_t             rd;
  logic               rd_fwd;
  logic [7:0]         rd_fwd_floor;
  logic [7:0]         mem_q;

  logic [ELEV_IW-1:0] fr_idx;
  logic [ELEV_IW-1:0] rd_idx;
  logic               rd_inside;
  logic               out_free;
  logic               rd_free;
  logic               fr_adv;
  logic               wr_floor;
  logic               wr_rst;
  logic [7:0]         stored;
  result_t            res_next;

  assign fr_idx    = fr.id[ELEV_IW-1:0];
  assign rd_idx    = rd.id[ELEV_IW-1:0];
  assign rd_inside = ({1'b0, rd.id} < ELEV_COUNT);

  assign out_free = !res_valid || res_ready;
  assign rd_free  = !rd_valid || out_free;
  assign fr_ready = rd_free;
  assign fr_adv   = fr_valid && rd_free;

  assign wr_floor = rd_valid && out_free && rd_inside && (rd.kind == KIND_FLOOR);
  assign wr_rst   = rd_valid && out_free && rd_inside && (rd.kind == KIND_RESET);

  // mem_q misses a write landing on the read edge itself: forward it
  assign stored = rd_fwd ? rd_fwd_floor : (floor_set[rd_idx] ? mem_q : FLOOR_RESET);

  always_comb begin
    res_next.kind = rd.kind;
    res_next.id   = rd.id;
    if (rd_inside) begin
      res_next.door_floor = (rd.kind == KIND_FLOOR) ? rd.floor : stored;
      res_next.reset_done = (rd.kind == KIND_RESET) || reset_ok[rd_idx];
      res_next.applied    = 1'b1;
    end else begin
      res_next.door_floor = 8'sd0;
      res_next.reset_done = 1'b0;
      res_next.applied    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid  <= 1'b0;
      res_valid <= 1'b0;
      floor_set <= '0;
      reset_ok  <= '0;
    end else begin
      if (rd_free) begin
        rd_valid <= fr_valid;
      end
      if (out_free) begin
        res_valid <= rd_valid;
      end
      if (wr_floor) begin
        floor_set[rd_idx] <= 1'b1;
      end
      if (wr_rst) begin
        reset_ok[rd_idx] <= 1'b1;
      end
    end
  end

  // floor memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (wr_floor) begin
      floor_mem[rd_idx] <= rd.floor;
    end
    if (fr_adv) begin
      mem_q <= floor_mem[fr_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rd_free) begin
      rd           <= fr;
      rd_fwd       <= wr_floor && (rd_idx == fr_idx);
      rd_fwd_floor <= rd.floor;
    end
    if (out_free) begin
      res <= res_next;
    end
  end

endmodule

// File: rtl/esfd_checker.sv
// ----------------------------------------------------------------------------
// esfd_checker
// Port-level checks on the deframer result stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "elevator_status_frame_deframer_macros.svh"

module esfd_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata,
  input logic [1:0]  m_tuser
);
  import esfd_pkg::*;

  // a stalled result holds
  `ESFD_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")

  // in-table flag follows the elevator id
  `ESFD_ASSERT_NOW(a_applied, m_tvalid, m_tdata[17] == ({1'b0, m_tdata[7:0]} < ELEV_COUNT), "entry_applied does not match elevator id")

  // ids outside the table report zero floor and flag
  `ESFD_ASSERT_NOW(a_outside, m_tvalid && !m_tdata[17], m_tdata[16:8] == 9'd0, "out-of-table result carries table data")

  // a reset acknowledge inside the table leaves the flag set
  `ESFD_ASSERT_NOW(a_rst_flag, m_tvalid && m_tdata[17] && m_tuser == KIND_RESET, m_tdata[16], "reset acknowledge without reset_done")

endmodule

bind elevator_status_frame_deframer esfd_checker u_esfd_checker (.*);

// File: test/tb_elevator_status_frame_deframer.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_elevator_status_frame_deframer
// Self-checking bench for the per-link elevator status frame deframer.
// Byte requests on four interleaved links go through a scoreboard that
// rebuilds the header hunt, the frame capture and the elevator table. Each
// frame result is checked field by field. The command codes change between
// phases while the block is idle, and the two sides idle at varying rates.
// ----------------------------------------------------------------------------
module tb_elevator_status_frame_deframer;
  import esfd_pkg::*;

  localparam int CLK_HALF   = 5;
  localparam int RST_CYCLES = 5;
  localparam int QUIET_MAX  = 4000;  // cycles with no request on either side
  localparam int SETTLE     = 8;     // pipeline is four registers deep
  localparam int SEQ_MAX    = 16;
  localparam logic [REG_IDX_W-1:0] REG_UNUSED = 2'd3;  // not a register

  typedef struct packed {
    logic [LINK_IW-1:0] link;
    logic [7:0]         data;
  } rx_item_t;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_wen;
  logic [REG_IDX_W-1:0] cfg_idx;
  logic [7:0]           cfg_data;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [7:0]           s_tdata;   // [7:0] rx_byte
  logic [1:0]           s_tuser;   // [1:0] link_id
  logic                 m_tvalid;
  logic                 m_tready;
  logic [23:0]          m_tdata;   // [7:0] elevator_number, [15:8] door_floor,
                                   // [16] reset_done, [17] entry_applied
  logic [1:0]           m_tuser;   // [1:0] frame_kind

  elevator_status_frame_deframer u_top (
    .clk      (clk),
    .rst      (rst),
    .cfg_wen  (cfg_wen),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Scoreboard state: bench copy of the codes, link phases, captures and the
  // elevator table, plus the frames still owed by the block.
  // --------------------------------------------------------------------------
  cfg_t       codes;
  phase_t     link_ph  [NUM_LINKS];
  logic [31:0] link_cap [NUM_LINKS];
  logic [7:0] floor_tbl [NUM_ELEVATORS];
  logic       rst_ok_tbl [NUM_ELEVATORS];
  result_t    owed_frames_q [$];
  rx_item_t   rx_bytes_q [$];

  int src_idle_pct;
  int sink_idle_pct;
  int mismatches;
  int bytes_sent;
  int frames_checked;
  int kind_seen [3];
  int outside_ids;
  int pushed_total;
  int quiet_cycles;
  logic byte_taken;

  // per-link byte sequences, interleaved into the request queue
  logic [7:0] seq [NUM_LINKS][SEQ_MAX];
  int         seq_len [NUM_LINKS];

  task automatic flag_mismatch(input string field, input int got, input int want);
    mismatches++;
    $display("%0t mismatch %s: got %0h want %0h", $time, field, got, want);
  endtask

  // Tracks one accepted byte; the eighth byte of a frame owes one result.
  task automatic deframe_byte(input logic [LINK_IW-1:0] lnk, input logic [7:0] b);
    phase_t     ph;
    result_t    r;
    logic [7:0] fl, fg, cm, id;
    if (int'(lnk) >= NUM_LINKS) return;  // unknown link: no effect at all
    ph = link_ph[lnk];
    case (ph)
      PH_HUNT: begin
        link_ph[lnk] = (b == HDR_FIRST) ? PH_HDR2 : PH_HUNT;
      end
      PH_HDR2: begin
        // repeated 0xAA keeps waiting for 0x55, anything else drops the hunt
        if (b == HDR_SECOND) link_ph[lnk] = PH_FLOOR;
        else if (b == HDR_FIRST) link_ph[lnk] = PH_HDR2;
        else link_ph[lnk] = PH_HUNT;
      end
      PH_CSUM: begin
        link_ph[lnk] = PH_HUNT;
        fl = link_cap[lnk][7:0];
        fg = link_cap[lnk][15:8];
        cm = link_cap[lnk][23:16];
        id = link_cap[lnk][31:24];
        // first match wins: arrival, then status ack (both need the flag),
        // then init ack
        if (cm == codes.arrival && fg == FLAG_VALID) r.kind = KIND_FLOOR;
        else if (cm == codes.status_ack && fg == FLAG_VALID) r.kind = KIND_FLOOR;
        else if (cm == codes.init_ack) r.kind = KIND_RESET;
        else r.kind = KIND_NONE;
        r.id = id;
        if (int'(id) < NUM_ELEVATORS) begin
          if (r.kind == KIND_FLOOR) floor_tbl[id] = fl;
          else if (r.kind == KIND_RESET) rst_ok_tbl[id] = 1'b1;
          r.door_floor = floor_tbl[id];
          r.reset_done = rst_ok_tbl[id];
          r.applied    = 1'b1;
        end else begin
          r.door_floor = '0;
          r.reset_done = 1'b0;
          r.applied    = 1'b0;
        end
        owed_frames_q = {owed_frames_q, r};
      end
      default: begin
        if (ph <= PH_ID) link_cap[lnk][(int'(ph) - 2) * 8 +: 8] = b;
        link_ph[lnk] = phase_t'(ph + 1);
      end
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Driver: the byte request changes at the falling edge; a held request
  // is left alone until the rising edge took it.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
      s_tuser  <= '0;
    end else if (!s_tvalid || byte_taken) begin
      if (rx_bytes_q.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
        s_tvalid <= 1'b1;
        {s_tuser, s_tdata} <= rx_bytes_q.pop_front();
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) m_tready <= 1'b0;
    else m_tready <= ($urandom_range(99) >= sink_idle_pct);
  end

  // --------------------------------------------------------------------------
  // Monitor: both requests sampled at the rising edge. A frame result can
  // only show once its last byte has passed the block's registers, so
  // checking before tracking the byte of the same edge is safe.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      byte_taken <= 1'b0;
    end else begin
      byte_taken <= s_tvalid && s_tready;
      if (m_tvalid && m_tready) begin
        if (owed_frames_q.size() == 0) begin
          flag_mismatch("result with none pending", int'(m_tdata), 0);
        end else begin
          want = owed_frames_q.pop_front();
          frames_checked++;
          if (int'(want.kind) < 3) kind_seen[want.kind]++;
          if (!want.applied) outside_ids++;
          if (m_tuser !== want.kind)
            flag_mismatch("frame_kind", int'(m_tuser), int'(want.kind));
          if (m_tdata[7:0] !== want.id)
            flag_mismatch("elevator_number", int'(m_tdata[7:0]), int'(want.id));
          if (m_tdata[15:8] !== want.door_floor)
            flag_mismatch("door_floor", int'(m_tdata[15:8]), int'(want.door_floor));
          if (m_tdata[16] !== want.reset_done)
            flag_mismatch("reset_done", int'(m_tdata[16]), int'(want.reset_done));
          if (m_tdata[17] !== want.applied)
            flag_mismatch("entry_applied", int'(m_tdata[17]), int'(want.applied));
        end
      end
      if (s_tvalid && s_tready) begin
        bytes_sent++;
        deframe_byte(s_tuser, s_tdata);
      end
    end
  end

  // Watchdog: any request on either side resets the quiet count.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_MAX) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic append_byte(input int l, input logic [7:0] b);
    seq[l][seq_len[l]] = b;
    seq_len[l]++;
  endtask

  task automatic add_frame(input int l, input bit dbl_hdr, input logic [7:0] floor,
                           input logic [7:0] flag, input logic [7:0] cmd,
                           input logic [7:0] id, input logic [7:0] robot,
                           input logic [7:0] csum);
    append_byte(l, HDR_FIRST);
    if (dbl_hdr) append_byte(l, HDR_FIRST);
    append_byte(l, HDR_SECOND);
    append_byte(l, floor);
    append_byte(l, flag);
    append_byte(l, cmd);
    append_byte(l, id);
    append_byte(l, robot);
    append_byte(l, csum);
  endtask

  // Interleaves the per-link sequences at random, keeping each link in order.
  task automatic flush_links();
    int pos [NUM_LINKS];
    int left;
    int l;
    rx_item_t it;
    left = 0;
    for (l = 0; l < NUM_LINKS; l++) begin
      pos[l] = 0;
      left += seq_len[l];
    end
    while (left > 0) begin
      l = $urandom_range(NUM_LINKS - 1);
      if (pos[l] < seq_len[l]) begin
        it.link = l[LINK_IW-1:0];
        it.data = seq[l][pos[l]];
        rx_bytes_q = {rx_bytes_q, it};
        pos[l]++;
        left--;
        pushed_total++;
      end
    end
    for (l = 0; l < NUM_LINKS; l++) seq_len[l] = 0;
  endtask

  // Mostly well-formed frames with random content; some noise, broken
  // headers and truncated frames.
  task automatic queue_traffic(input int n_bytes);
    int start, l, n, pick;
    logic [7:0] b, cmd, flag, id;
    start = pushed_total;
    while (pushed_total - start < n_bytes) begin
      for (l = 0; l < NUM_LINKS; l++) begin
        if ($urandom_range(99) < 15) continue;
        if ($urandom_range(99) < 20)
          for (n = $urandom_range(3, 1); n > 0; n--) append_byte(l, 8'($urandom_range(255)));
        pick = $urandom_range(99);
        if (pick < 8) begin
          append_byte(l, HDR_FIRST);
          if ($urandom_range(1)) begin
            do b = 8'($urandom_range(255)); while (b == HDR_SECOND);
            append_byte(l, b);
          end
        end else if (pick < 12) begin
          append_byte(l, HDR_FIRST);
          append_byte(l, HDR_SECOND);
          for (n = $urandom_range(5, 1); n > 0; n--) append_byte(l, 8'($urandom_range(255)));
        end else begin
          case ($urandom_range(3))
            0: cmd = codes.arrival;
            1: cmd = codes.status_ack;
            2: cmd = codes.init_ack;
            default: cmd = 8'($urandom_range(255));
          endcase
          flag = ($urandom_range(99) < 65) ? FLAG_VALID : 8'($urandom_range(255));
          id = ($urandom_range(99) < 80) ? 8'($urandom_range(NUM_ELEVATORS - 1))
                                         : 8'($urandom_range(255));
          add_frame(l, $urandom_range(99) < 25, 8'($urandom_range(255)), flag, cmd, id,
                    8'($urandom_range(255)), 8'($urandom_range(255)));
        end
      end
      flush_links();
    end
  endtask

  // Waits until every byte went in and every owed frame came out.
  task automatic drain();
    while (rx_bytes_q.size() > 0 || s_tvalid || owed_frames_q.size() > 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Register writes only happen with the block idle.
  task automatic write_code(input logic [REG_IDX_W-1:0] idx, input logic [7:0] val);
    @(negedge clk);
    cfg_wen  <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    case (idx)
      REG_ARRIVAL:    codes.arrival    = val;
      REG_STATUS_ACK: codes.status_ack = val;
      REG_INIT_ACK:   codes.init_ack   = val;
      default: ;  // outside the list: ignored
    endcase
    @(negedge clk);
    cfg_wen <= 1'b0;
  endtask

  task automatic set_codes(input logic [7:0] a, input logic [7:0] s, input logic [7:0] i);
    write_code(REG_ARRIVAL, a);
    write_code(REG_STATUS_ACK, s);
    write_code(REG_INIT_ACK, i);
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    logic [7:0] same;
    rst      = 1'b1;
    cfg_wen  = 1'b0;
    cfg_idx  = '0;
    cfg_data = '0;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = '0;
    m_tready = 1'b0;
    src_idle_pct  = 18;
    sink_idle_pct = 50;
    mismatches = 0;
    bytes_sent = 0;
    frames_checked = 0;
    outside_ids = 0;
    pushed_total = 0;
    for (int k = 0; k < 3; k++) kind_seen[k] = 0;
    codes.arrival    = 8'd0;
    codes.status_ack = 8'd1;
    codes.init_ack   = 8'd2;
    for (int l = 0; l < NUM_LINKS; l++) begin
      link_ph[l]  = PH_HUNT;
      link_cap[l] = '0;
      seq_len[l]  = 0;
    end
    for (int e = 0; e < NUM_ELEVATORS; e++) begin
      floor_tbl[e]  = FLOOR_RESET;
      rst_ok_tbl[e] = 1'b0;
    end

    repeat (RST_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed, reset codes: arrival with a doubled header and the lowest
    // floor, status ack at the top entry with the highest floor, init ack
    // with an id outside the table
    add_frame(0, 1, 8'h80, FLAG_VALID, 8'd0, 8'd0, 8'hFF, 8'hFF);
    add_frame(3, 0, 8'h7F, FLAG_VALID, 8'd1, 8'(NUM_ELEVATORS - 1), 8'h00, 8'h00);
    add_frame(1, 0, 8'h00, 8'h00, 8'd2, 8'hFF, 8'h00, 8'h00);
    flush_links();
    drain();

    // sender idles lightly, receiver half the time
    set_codes(8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(255)));
    queue_traffic(400);
    drain();

    // sides swapped; extreme codes with init ack overlapping arrival
    src_idle_pct  = 50;
    sink_idle_pct = 18;
    set_codes(8'hFF, 8'h00, 8'hFF);
    queue_traffic(400);
    drain();

    // no idling; all three codes equal so the decision order matters
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    same = 8'($urandom_range(255));
    set_codes(same, same, same);
    queue_traffic(400);
    drain();

    // a write outside the register list must leave the codes alone
    write_code(REG_UNUSED, 8'hFF);
    set_codes(8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(255)));
    write_code(REG_UNUSED, 8'($urandom_range(255)));
    queue_traffic(400);
    drain();

    if (owed_frames_q.size() != 0)
      flag_mismatch("frames never reported", owed_frames_q.size(), 0);
    $display("covered %0d bytes on %0d links, %0d frames checked", bytes_sent, NUM_LINKS,
             frames_checked);
    $display("floor updates %0d, reset acks %0d, no effect %0d, ids outside table %0d",
             kind_seen[0], kind_seen[1], kind_seen[2], outside_ids);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl
rtl/esfd_pkg.sv
rtl/esfd_link_framer.sv
rtl/esfd_elev_table.sv
rtl/elevator_status_frame_deframer.sv
rtl/esfd_checker.sv
test/tb_elevator_status_frame_deframer.sv
